@@ rtl/scfe_pkg.sv @@
// ----------------------------------------------------------------------------
// scfe_pkg
// Shared types, codes and frame helpers of the serial command frame engine.
// ----------------------------------------------------------------------------
package scfe_pkg;

  localparam int unsigned FRAME_BYTES = 10;
  localparam int unsigned IDX_W       = $clog2(FRAME_BYTES);

  localparam int unsigned CODE_W  = 8;
  localparam int unsigned ARG_W   = 16;
  localparam int unsigned TICK_W  = 20;
  localparam int unsigned GAP_W   = 16;
  localparam int unsigned CFG_W   = 20;
  localparam int unsigned CFG_IDX_W = 2;

  // Input modes
  localparam logic [1:0] MODE_CMD  = 2'd0;
  localparam logic [1:0] MODE_RX   = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;
  localparam logic [1:0] MODE_WAIT = 2'd3;

  // Status codes
  localparam logic [1:0] ST_MATCH   = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_ABORT   = 2'd2;
  localparam logic [1:0] ST_REJECT  = 2'd3;

  // Result kinds
  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_CODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESP_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP    = 2'd2;

  // Frame constants
  localparam logic [7:0] FR_START = 8'h7E;
  localparam logic [7:0] FR_VER   = 8'hFF;
  localparam logic [7:0] FR_LEN   = 8'h06;
  localparam logic [7:0] FR_FB    = 8'h01;
  localparam logic [7:0] FR_END   = 8'hEF;

  localparam logic [IDX_W-1:0] IDX_CODE = IDX_W'(3);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_BYTES - 1);

  // Job handed from the front to the back
  typedef struct packed {
    logic              is_frame;
    logic [CODE_W-1:0] cmd;
    logic [ARG_W-1:0]  arg;
    logic [1:0]        status;
  } job_t;

  // Byte expected by the acknowledge matcher; zero matches anything
  function automatic logic [7:0] expected_byte(input logic [IDX_W-1:0] idx,
                                               input logic [7:0] code);
    logic [7:0] b;
    case (idx)
      IDX_W'(0): b = FR_START;
      IDX_W'(1): b = FR_VER;
      IDX_W'(2): b = FR_LEN;
      IDX_CODE:  b = code;
      IDX_LAST:  b = FR_END;
      default:   b = 8'h00;
    endcase
    return b;
  endfunction

  // One byte of an outgoing command frame
  function automatic logic [7:0] frame_byte(input logic [IDX_W-1:0] idx,
                                            input logic [CODE_W-1:0] cmd,
                                            input logic [ARG_W-1:0] arg);
    logic [15:0] sum;
    logic [15:0] chk;
    logic [7:0]  b;
    sum = 16'(FR_VER) + 16'(FR_LEN) + 16'(FR_FB) + 16'(cmd)
        + 16'(arg[15:8]) + 16'(arg[7:0]);
    chk = 16'(16'd0 - sum);
    case (idx)
      IDX_W'(0): b = FR_START;
      IDX_W'(1): b = FR_VER;
      IDX_W'(2): b = FR_LEN;
      IDX_CODE:  b = cmd;
      IDX_W'(4): b = FR_FB;
      IDX_W'(5): b = arg[15:8];
      IDX_W'(6): b = arg[7:0];
      IDX_W'(7): b = chk[15:8];
      IDX_W'(8): b = chk[7:0];
      IDX_LAST:  b = FR_END;
      default:   b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/scfe_if.sv @@
// ----------------------------------------------------------------------------
// scfe_in_if / scfe_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface scfe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  command_code;
  logic [15:0] argument;
  logic [7:0]  rx_byte;
  logic [7:0]  expected_code;
  logic [19:0] wait_ticks;
  logic        abort_enable;
  logic        abort_level;

  modport source (output valid, mode, command_code, argument, rx_byte,
                  expected_code, wait_ticks, abort_enable, abort_level,
                  input ready);
  modport sink (input valid, mode, command_code, argument, rx_byte,
                expected_code, wait_ticks, abort_enable, abort_level,
                output ready);
endinterface

interface scfe_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] tx_byte;
  logic [1:0] status;
  logic       last;

  modport source (output valid, kind, tx_byte, status, last, input ready);
  modport sink (input valid, kind, tx_byte, status, last, output ready);
endinterface

@@ rtl/scfe_front.sv @@
// ----------------------------------------------------------------------------
// scfe_front
// Classifies each input transaction, updates wait, matcher and gap state,
// and issues a job for every transaction that produces results.
// ----------------------------------------------------------------------------
module scfe_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic [1:0]                          mode_i,
  input  logic [scfe_pkg::CODE_W-1:0]         command_code_i,
  input  logic [scfe_pkg::ARG_W-1:0]          argument_i,
  input  logic [7:0]                          rx_byte_i,
  input  logic [scfe_pkg::CODE_W-1:0]         expected_code_i,
  input  logic [scfe_pkg::TICK_W-1:0]         wait_ticks_i,
  input  logic                                abort_enable_i,
  input  logic                                abort_level_i,
  input  logic                                cfg_we_i,
  input  logic [scfe_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [scfe_pkg::CFG_W-1:0]          cfg_data_i,
  output logic                                push_o,
  output scfe_pkg::job_t                      job_o
);

  logic [scfe_pkg::CODE_W-1:0] ack_code_q;
  logic [scfe_pkg::TICK_W-1:0] resp_limit_q;
  logic [scfe_pkg::GAP_W-1:0]  min_gap_q;

  logic                        waiting_q, waiting_d;
  logic [scfe_pkg::IDX_W-1:0]  match_idx_q, match_idx_d;
  logic [scfe_pkg::CODE_W-1:0] awaited_q, awaited_d;
  logic [scfe_pkg::TICK_W-1:0] timer_q, timer_d;
  logic [scfe_pkg::TICK_W-1:0] limit_q, limit_d;
  logic                        after_cmd_q, after_cmd_d;
  logic [scfe_pkg::GAP_W-1:0]  gap_q, gap_d;

  logic [7:0] want;
  logic       hit;

  assign want = scfe_pkg::expected_byte(match_idx_q, awaited_q);
  assign hit  = (want == 8'h00) || (rx_byte_i == want);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_code_q   <= scfe_pkg::CODE_W'(65);
      resp_limit_q <= scfe_pkg::TICK_W'(500);
      min_gap_q    <= scfe_pkg::GAP_W'(100);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        scfe_pkg::CFG_ACK_CODE:   ack_code_q   <= cfg_data_i[scfe_pkg::CODE_W-1:0];
        scfe_pkg::CFG_RESP_LIMIT: resp_limit_q <= cfg_data_i[scfe_pkg::TICK_W-1:0];
        scfe_pkg::CFG_MIN_GAP:    min_gap_q    <= cfg_data_i[scfe_pkg::GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    waiting_d   = waiting_q;
    match_idx_d = match_idx_q;
    awaited_d   = awaited_q;
    timer_d     = timer_q;
    limit_d     = limit_q;
    after_cmd_d = after_cmd_q;
    gap_d       = gap_q;
    push_o      = 1'b0;
    job_o       = '0;
    job_o.cmd   = command_code_i;
    job_o.arg   = argument_i;

    if (accept_i) begin
      case (mode_i)
        scfe_pkg::MODE_CMD: begin
          push_o = 1'b1;
          if (waiting_q || (gap_q < min_gap_q)) begin
            job_o.status = scfe_pkg::ST_REJECT;
          end else begin
            job_o.is_frame = 1'b1;
            waiting_d      = 1'b1;
            match_idx_d    = '0;
            awaited_d      = ack_code_q;
            timer_d        = '0;
            limit_d        = resp_limit_q;
            after_cmd_d    = 1'b1;
          end
        end
        scfe_pkg::MODE_RX: begin
          if (waiting_q) begin
            if (!hit) begin
              match_idx_d = '0;
            end else if (match_idx_q == scfe_pkg::IDX_LAST) begin
              // full acknowledge seen: close the wait
              push_o       = 1'b1;
              job_o.status = scfe_pkg::ST_MATCH;
              if (after_cmd_q) gap_d = '0;
              waiting_d    = 1'b0;
              match_idx_d  = '0;
              timer_d      = '0;
              after_cmd_d  = 1'b0;
            end else begin
              match_idx_d = match_idx_q + scfe_pkg::IDX_W'(1);
            end
          end
        end
        scfe_pkg::MODE_TICK: begin
          if (gap_q != '1) gap_d = gap_q + scfe_pkg::GAP_W'(1);
          if (waiting_q) begin
            if ((!after_cmd_q && abort_enable_i && !abort_level_i) ||
                (timer_q >= limit_q)) begin
              push_o       = 1'b1;
              job_o.status = (!after_cmd_q && abort_enable_i && !abort_level_i)
                             ? scfe_pkg::ST_ABORT : scfe_pkg::ST_TIMEOUT;
              if (after_cmd_q) gap_d = '0;
              waiting_d    = 1'b0;
              match_idx_d  = '0;
              timer_d      = '0;
              after_cmd_d  = 1'b0;
            end else begin
              timer_d = timer_q + scfe_pkg::TICK_W'(1);
            end
          end
        end
        scfe_pkg::MODE_WAIT: begin
          if (waiting_q) begin
            push_o       = 1'b1;
            job_o.status = scfe_pkg::ST_REJECT;
          end else begin
            waiting_d   = 1'b1;
            match_idx_d = '0;
            awaited_d   = expected_code_i;
            timer_d     = '0;
            limit_d     = wait_ticks_i;
            after_cmd_d = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting_q   <= 1'b0;
      match_idx_q <= '0;
      awaited_q   <= '0;
      timer_q     <= '0;
      limit_q     <= '0;
      after_cmd_q <= 1'b0;
      gap_q       <= '1;
    end else begin
      waiting_q   <= waiting_d;
      match_idx_q <= match_idx_d;
      awaited_q   <= awaited_d;
      timer_q     <= timer_d;
      limit_q     <= limit_d;
      after_cmd_q <= after_cmd_d;
      gap_q       <= gap_d;
    end
  end

endmodule

@@ rtl/scfe_queue.sv @@
// ----------------------------------------------------------------------------
// scfe_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module scfe_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  scfe_pkg::job_t job_i,
  output logic           full_o,
  output logic           head_valid_o,
  output scfe_pkg::job_t head_o,
  input  logic           pop_i
);

  scfe_pkg::job_t slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o       = count_q[1];
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

@@ rtl/scfe_back.sv @@
// ----------------------------------------------------------------------------
// scfe_back
// Turns queued jobs into result transactions: ten frame bytes for an accepted command,
// one status report otherwise. Results leave through an output register.
// ----------------------------------------------------------------------------
module scfe_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  scfe_pkg::job_t head_i,
  output logic           pop_o,
  scfe_out_if.source     out_chan
);

  logic [scfe_pkg::IDX_W-1:0] byte_idx_q, byte_idx_d;
  logic       valid_q, valid_d;
  logic       kind_q, kind_d;
  logic [7:0] tx_q, tx_d;
  logic [1:0] status_q, status_d;
  logic       last_q, last_d;
  logic       load;

  assign load = !valid_q || out_chan.ready;

  always_comb begin
    byte_idx_d = byte_idx_q;
    valid_d    = valid_q;
    kind_d     = kind_q;
    tx_d       = tx_q;
    status_d   = status_q;
    last_d     = last_q;
    pop_o      = 1'b0;
    if (load) begin
      valid_d = head_valid_i;
      if (head_valid_i) begin
        if (head_i.is_frame) begin
          kind_d   = scfe_pkg::KIND_TX;
          tx_d     = scfe_pkg::frame_byte(byte_idx_q, head_i.cmd, head_i.arg);
          status_d = scfe_pkg::ST_MATCH;
          last_d   = (byte_idx_q == scfe_pkg::IDX_LAST);
          if (byte_idx_q == scfe_pkg::IDX_LAST) begin
            pop_o      = 1'b1;
            byte_idx_d = '0;
          end else begin
            byte_idx_d = byte_idx_q + scfe_pkg::IDX_W'(1);
          end
        end else begin
          kind_d   = scfe_pkg::KIND_STATUS;
          tx_d     = 8'h00;
          status_d = head_i.status;
          last_d   = 1'b1;
          pop_o    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_idx_q <= '0;
      valid_q    <= 1'b0;
    end else begin
      byte_idx_q <= byte_idx_d;
      valid_q    <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    tx_q     <= tx_d;
    status_q <= status_d;
    last_q   <= last_d;
  end

  assign out_chan.valid   = valid_q;
  assign out_chan.kind    = kind_q;
  assign out_chan.tx_byte = tx_q;
  assign out_chan.status  = status_q;
  assign out_chan.last    = last_q;

endmodule

@@ rtl/serial_command_frame_engine.sv @@
// ----------------------------------------------------------------------------
// serial_command_frame_engine
// Builds command frames for a serial audio module, matches acknowledge
// frames, and tracks response timeouts and the gap between commands.
// ----------------------------------------------------------------------------
//   channel   dir  handshake      payload
//   in_chan   in   valid/ready    mode, command_code, argument, rx_byte,
//                                 expected_code, wait_ticks, abort_*
//   out_chan  out  valid/ready    kind, tx_byte, status, last
//   cfg       in   cfg_we_i       cfg_index_i, cfg_data_i (20 bits)
//
// Every input transaction is classified in the cycle it is accepted; a new one is taken each
// cycle while the two-entry job queue has room. An accepted command drains its ten frame
// bytes at one per cycle through the output register while the output is ready; a status
// report is a single result. Output stalls back up into the queue, and into the input once
// both queue entries are taken.
// Reset clears all control state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module serial_command_frame_engine (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  scfe_in_if.sink                         in_chan,
  scfe_out_if.source                      out_chan,
  input  logic                            cfg_we_i,
  input  logic [scfe_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [scfe_pkg::CFG_W-1:0]      cfg_data_i
);

  logic           accept;
  logic           push;
  logic           full;
  logic           head_valid;
  logic           pop;
  scfe_pkg::job_t job;
  scfe_pkg::job_t head;

  assign in_chan.ready = !full;
  assign accept        = in_chan.valid && !full;

  scfe_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .mode_i          (in_chan.mode),
    .command_code_i  (in_chan.command_code),
    .argument_i      (in_chan.argument),
    .rx_byte_i       (in_chan.rx_byte),
    .expected_code_i (in_chan.expected_code),
    .wait_ticks_i    (in_chan.wait_ticks),
    .abort_enable_i  (in_chan.abort_enable),
    .abort_level_i   (in_chan.abort_level),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .push_o          (push),
    .job_o           (job)
  );

  scfe_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .job_i        (job),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  scfe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_chan     (out_chan)
  );

endmodule

@@ test/serial_command_frame_engine_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_command_frame_engine_checker
// Watches the item and result channels and the register port of the command
// frame engine, keeps its own copy of the engine state, queues the results
// each accepted item must produce and compares every result field by field.
// ----------------------------------------------------------------------------
module serial_command_frame_engine_checker
  import scfe_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  scfe_in_if                   in_mon,
  scfe_out_if                  out_mon,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);

  typedef struct packed {
    logic       kind;
    logic [7:0] tx_byte;
    logic [1:0] status;
    logic       last;
  } engine_result_t;

  engine_result_t outgoing_q[$];
  int unsigned    n_errors;

  // Register copies
  logic [CODE_W-1:0] ack_code_r;
  logic [TICK_W-1:0] resp_limit_r;
  logic [GAP_W-1:0]  min_gap_r;

  // Engine state copy
  logic              waiting;
  logic [3:0]        match_pos;
  logic [7:0]        awaited;
  logic [TICK_W-1:0] wait_count;
  logic [TICK_W-1:0] wait_limit;
  logic              cmd_wait;
  logic [GAP_W-1:0]  gap_count;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    n_errors++;
  endtask

  function automatic void push_tx_byte(input logic [7:0] b, input logic is_last);
    outgoing_q.push_back('{kind: KIND_TX, tx_byte: b, status: ST_MATCH, last: is_last});
  endfunction

  function automatic void push_status(input logic [1:0] st);
    outgoing_q.push_back('{kind: KIND_STATUS, tx_byte: 8'h00, status: st, last: 1'b1});
  endfunction

  function automatic void open_wait(input logic [7:0] code, input logic [TICK_W-1:0] lim,
                                    input logic after_cmd);
    waiting    = 1'b1;
    match_pos  = 4'd0;
    awaited    = code;
    wait_count = '0;
    wait_limit = lim;
    cmd_wait   = after_cmd;
  endfunction

  function automatic void close_wait(input logic [1:0] st);
    // a finished acknowledge wait restarts the inter-command gap
    if (cmd_wait) gap_count = '0;
    waiting    = 1'b0;
    match_pos  = 4'd0;
    wait_count = '0;
    cmd_wait   = 1'b0;
    push_status(st);
  endfunction

  function automatic void step_engine();
    logic [7:0]  frame [FRAME_BYTES];
    logic [15:0] sum;
    logic [15:0] chk;
    logic [7:0]  want;
    logic [7:0]  cmd;
    logic [15:0] arg;
    cmd = in_mon.command_code;
    arg = in_mon.argument;
    case (in_mon.mode)
      MODE_CMD: begin
        if (waiting || gap_count < min_gap_r) begin
          push_status(ST_REJECT);
        end else begin
          sum = 16'(FR_VER) + 16'(FR_LEN) + 16'(cmd) + 16'(FR_FB)
              + 16'(arg[15:8]) + 16'(arg[7:0]);
          chk = ~sum + 16'd1;
          frame = '{FR_START, FR_VER, FR_LEN, cmd, FR_FB, arg[15:8], arg[7:0],
                    chk[15:8], chk[7:0], FR_END};
          for (int i = 0; i < FRAME_BYTES; i++) push_tx_byte(frame[i], i == FRAME_BYTES - 1);
          open_wait(ack_code_r, resp_limit_r, 1'b1);
        end
      end
      MODE_RX: begin
        if (waiting) begin
          case (match_pos)
            4'd0:    want = FR_START;
            4'd1:    want = FR_VER;
            4'd2:    want = FR_LEN;
            4'd3:    want = awaited;
            4'd9:    want = FR_END;
            default: want = 8'h00;
          endcase
          // a mismatching byte restarts the search without being rechecked
          if (want == 8'h00 || in_mon.rx_byte == want) match_pos = match_pos + 4'd1;
          else match_pos = 4'd0;
          if (match_pos >= 4'(FRAME_BYTES)) close_wait(ST_MATCH);
        end
      end
      MODE_TICK: begin
        if (gap_count != '1) gap_count = gap_count + 1'b1;
        if (waiting) begin
          if (!cmd_wait && in_mon.abort_enable && !in_mon.abort_level) close_wait(ST_ABORT);
          else if (wait_count >= wait_limit) close_wait(ST_TIMEOUT);
          else wait_count = wait_count + 1'b1;
        end
      end
      default: begin
        if (waiting) push_status(ST_REJECT);
        else open_wait(in_mon.expected_code, in_mon.wait_ticks, 1'b0);
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    engine_result_t want;
    if (!rst_ni) begin
      outgoing_q.delete();
      n_errors     = 0;
      ack_code_r   = 8'd65;
      resp_limit_r = 20'd500;
      min_gap_r    = 16'd100;
      waiting      = 1'b0;
      match_pos    = 4'd0;
      awaited      = 8'h00;
      wait_count   = '0;
      wait_limit   = '0;
      cmd_wait     = 1'b0;
      gap_count    = '1;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ACK_CODE:   ack_code_r   = cfg_data_i[CODE_W-1:0];
          CFG_RESP_LIMIT: resp_limit_r = cfg_data_i[TICK_W-1:0];
          CFG_MIN_GAP:    min_gap_r    = cfg_data_i[GAP_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) step_engine();
      if (out_mon.valid && out_mon.ready) begin
        if (outgoing_q.size() == 0) begin
          report_mismatch("unexpected result",
                          {out_mon.kind, out_mon.tx_byte, out_mon.status, out_mon.last}, 0);
        end else begin
          want = outgoing_q.pop_front();
          if (out_mon.kind !== want.kind) report_mismatch("kind", out_mon.kind, want.kind);
          if (out_mon.tx_byte !== want.tx_byte)
            report_mismatch("tx_byte", out_mon.tx_byte, want.tx_byte);
          if (out_mon.status !== want.status)
            report_mismatch("status", out_mon.status, want.status);
          if (out_mon.last !== want.last) report_mismatch("last", out_mon.last, want.last);
        end
      end
      fail_count_o <= n_errors;
      pending_o    <= outgoing_q.size();
    end
  end

endmodule

@@ test/serial_command_frame_engine_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_command_frame_engine_tb
// Drives commands, received bytes, ticks and wait requests into the frame
// engine through several register settings, with random gaps on the input
// and random stalls on the output; the checker predicts and compares.
// ----------------------------------------------------------------------------
module serial_command_frame_engine_tb;
  import scfe_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 16;
  // Longest legal quiet stretch is an input gap plus an output stall plus the settle time
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned ITEMS_PER_SET = 16;
  localparam int unsigned NUM_SETTINGS  = 6;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int unsigned          fail_count;
  int unsigned          pending_results;

  scfe_in_if  in_chan ();
  scfe_out_if out_chan ();

  // Register values currently loaded
  logic [CODE_W-1:0] cur_ack;
  logic [TICK_W-1:0] cur_limit;
  logic [GAP_W-1:0]  cur_gap;

  bit          calm;
  int unsigned items_sent;

  serial_command_frame_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  serial_command_frame_engine_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_chan),
    .out_mon      (out_chan),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic put_item(input logic [1:0] mode, input logic [7:0] code,
                          input logic [15:0] arg, input logic [7:0] rx,
                          input logic [7:0] want_code, input logic [19:0] ticks,
                          input logic ab_en, input logic ab_lvl);
    int unsigned hold;
    hold = calm ? 0 : idle_len();
    if (hold != 0) begin
      in_chan.valid <= 1'b0;
      repeat (hold) @(posedge clk_i);
    end
    in_chan.valid         <= 1'b1;
    in_chan.mode          <= mode;
    in_chan.command_code  <= code;
    in_chan.argument      <= arg;
    in_chan.rx_byte       <= rx;
    in_chan.expected_code <= want_code;
    in_chan.wait_ticks    <= ticks;
    in_chan.abort_enable  <= ab_en;
    in_chan.abort_level   <= ab_lvl;
    do @(posedge clk_i); while (!in_chan.ready);
    items_sent++;
  endtask

  task automatic send_cmd(input logic [7:0] code, input logic [15:0] arg);
    put_item(MODE_CMD, code, arg, 8'($urandom), 8'($urandom), 20'($urandom),
             1'($urandom), 1'($urandom));
  endtask

  task automatic send_rx(input logic [7:0] b);
    put_item(MODE_RX, 8'($urandom), 16'($urandom), b, 8'($urandom), 20'($urandom),
             1'($urandom), 1'($urandom));
  endtask

  task automatic send_tick(input logic ab_en, input logic ab_lvl);
    put_item(MODE_TICK, 8'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
             20'($urandom), ab_en, ab_lvl);
  endtask

  task automatic send_wait(input logic [7:0] code, input logic [19:0] ticks);
    put_item(MODE_WAIT, 8'($urandom), 16'($urandom), 8'($urandom), code, ticks,
             1'($urandom), 1'($urandom));
  endtask

  // Acknowledge-style frame; zero code and the padding bytes take random content
  task automatic send_frame(input logic [7:0] code);
    if ($urandom_range(0, 4) == 0) begin
      send_rx(FR_START);
      send_rx(8'($urandom));
    end
    send_rx(FR_START);
    send_rx(FR_VER);
    send_rx(FR_LEN);
    send_rx(code == 8'h00 ? 8'($urandom) : code);
    repeat (5) send_rx(8'($urandom));
    send_rx(FR_END);
  endtask

  task automatic send_noise();
    put_item(2'($urandom), 8'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
             ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 6)),
             1'($urandom), 1'($urandom));
  endtask

  task automatic load_regs(input logic [7:0] ack, input logic [19:0] lim,
                           input logic [15:0] gap);
    cur_ack   = ack;
    cur_limit = lim;
    cur_gap   = gap;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ACK_CODE;
    cfg_data  <= CFG_W'(ack);
    @(posedge clk_i);
    cfg_index <= CFG_RESP_LIMIT;
    cfg_data  <= CFG_W'(lim);
    @(posedge clk_i);
    cfg_index <= CFG_MIN_GAP;
    cfg_data  <= CFG_W'(gap);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Hold off until every predicted result is out, then let stragglers settle
  task automatic quiesce();
    in_chan.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_sequence();
    int unsigned pick;
    logic [7:0]  code;
    logic [19:0] lim;
    pick = $urandom_range(0, 99);
    calm = ($urandom_range(0, 4) == 0);
    if (pick < 35) begin
      send_cmd(8'($urandom), 16'($urandom));
      repeat ($urandom_range(0, 2)) send_tick(1'($urandom), 1'($urandom));
      if (cur_limit <= 16 && $urandom_range(0, 2) == 0)
        repeat (cur_limit + 1) send_tick(1'($urandom), 1'($urandom));
      else
        send_frame(cur_ack);
      if (cur_gap <= 20) repeat (cur_gap) send_tick(1'($urandom), 1'($urandom));
    end else if (pick < 65) begin
      code = ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom);
      lim  = ($urandom_range(0, 4) == 0) ? 20'($urandom) : 20'($urandom_range(0, 8));
      send_wait(code, lim);
      case ($urandom_range(0, 2))
        0: send_frame(code);
        1: begin
          if (lim <= 16) repeat (lim + 1) send_tick(1'b0, 1'($urandom));
          else send_tick(1'b1, 1'b0);
        end
        default: begin
          repeat ($urandom_range(0, 2)) send_rx(8'($urandom));
          send_tick(1'b1, 1'b0);
        end
      endcase
    end else begin
      repeat ($urandom_range(1, 3)) send_noise();
    end
  endtask

  // Result side: runs of ready broken by stalls of random length
  initial begin
    int unsigned stall;
    out_chan.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      out_chan.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      stall = idle_len();
      if (!calm && stall != 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // End the run when no transaction moves on either channel for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) quiet = 0;
      else quiet++;
    end
    $display("serial_command_frame_engine_tb NOT OK");
    $finish;
  end

  initial begin
    int unsigned start;
    items_sent            = 0;
    calm                  = 1'b0;
    rst_ni                <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_index             <= CFG_ACK_CODE;
    cfg_data              <= '0;
    in_chan.valid         <= 1'b0;
    in_chan.mode          <= MODE_TICK;
    in_chan.command_code  <= '0;
    in_chan.argument      <= '0;
    in_chan.rx_byte       <= '0;
    in_chan.expected_code <= '0;
    in_chan.wait_ticks    <= '0;
    in_chan.abort_enable  <= 1'b0;
    in_chan.abort_level   <= 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part
    load_regs(8'h41, 20'd3, 16'd2);
    send_cmd(8'h00, 16'h0000);
    send_cmd(8'hFF, 16'hFFFF);       // refused: acknowledge wait active
    send_wait(8'hFF, 20'hFFFFF);     // refused: wait active
    send_rx(FR_START);
    send_rx(8'h00);                  // mismatch drops back to the start byte
    send_frame(8'h41);
    send_cmd(8'h12, 16'h3456);       // refused: gap too short
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_cmd(8'hFF, 16'hFFFF);
    repeat (4) send_tick(1'b1, 1'b0); // abort has no effect on a command wait
    send_rx(8'hFF);                  // idle byte, dropped
    send_wait(8'h00, 20'd0);
    send_frame(8'h00);
    send_wait(8'hAB, 20'hFFFFF);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_wait(8'h05, 20'd0);
    send_tick(1'b0, 1'b1);
    quiesce();

    // Random part over several register settings
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      case (s)
        1:       load_regs(8'h00, 20'd0, 16'd0);
        2:       load_regs(8'hFF, 20'hFFFFF, 16'd0);
        4:       load_regs(8'($urandom), 20'd2, 16'hFFFF);
        default: load_regs(8'($urandom), 20'($urandom_range(0, 8)), 16'($urandom_range(0, 4)));
      endcase
      start = items_sent;
      while (items_sent - start < ITEMS_PER_SET) run_sequence();
      calm = 1'b0;
      quiesce();
    end

    if (fail_count == 0) begin
      $display("serial_command_frame_engine_tb OK");
    end else begin
      $display("serial_command_frame_engine_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/scfe_pkg.sv
rtl/scfe_if.sv
rtl/scfe_front.sv
rtl/scfe_queue.sv
rtl/scfe_back.sv
rtl/serial_command_frame_engine.sv
test/serial_command_frame_engine_checker.sv
test/serial_command_frame_engine_tb.sv
